FILE: rtl/core/bcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_pkg: shared types and codes of the button chord detector
// Word formats, chord and state records, command, event and register codes.
// ----------------------------------------------------------------------------
package bcd_pkg;

  localparam int unsigned BUTTON_W   = 32;
  localparam int unsigned AXIS_W     = 8;
  localparam int unsigned EVENT_W    = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [AXIS_W-1:0] THRESHOLD_RESET = 8'd128;

  // Commands carried in the cmd field.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FIRE   = 1'b1;

  // Fired chord selector.
  localparam logic ACT_HOME  = 1'b0;
  localparam logic ACT_QUICK = 1'b1;

  // Timer actions reported per chord.
  localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
  localparam logic [EVENT_W-1:0] EV_ARM    = 2'd1;
  localparam logic [EVENT_W-1:0] EV_CANCEL = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HOME_BUTTONS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOME_TRIGGERS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUICK_BUTTONS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_QUICK_TRIGGERS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_THRESHOLD = 3'd4;

  typedef struct packed {
    logic [BUTTON_W-1:0] buttons;
    logic                lt;
    logic                rt;
  } bcd_chord_t;

  typedef struct packed {
    logic [BUTTON_W-1:0] suppressed_mask;
    logic                suppress_left;
    logic                suppress_right;
    logic [1:0]          armed_flags;
  } bcd_state_t;

  typedef struct packed {
    logic                cmd;
    logic                fire_action;
    logic [BUTTON_W-1:0] buttons_in;
    logic [AXIS_W-1:0]   left_in;
    logic [AXIS_W-1:0]   right_in;
  } bcd_in_t;

  typedef struct packed {
    logic [BUTTON_W-1:0] buttons_out;
    logic [AXIS_W-1:0]   left_out;
    logic [AXIS_W-1:0]   right_out;
    logic [EVENT_W-1:0]  home_event;
    logic [EVENT_W-1:0]  quick_event;
  } bcd_out_t;

endpackage

FILE: rtl/core/button_chord_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_chord_detector_unit: home and quick access chord detector
// Filters gamepad samples against two configured chords, tracks which
// chords are armed for the external hold timer and masks suppressed inputs.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                      | Word
//  --------+------------------------------+-------------------------------
//  input   | in_valid, in_ready, in_data  | bcd_in_t: command and sample
//  output  | out_valid, out_ready,        | bcd_out_t: filtered sample and
//          | out_data                     | home and quick timer events
//  config  | cfg_we, cfg_index, cfg_data  | register write, no read-back
//
// Each input word is evaluated in the cycle it is accepted and its result lands in the
// output register at that edge, so one word per cycle is sustained while out_ready stays high.
// The block holds one result register: in_ready is high while that register is empty or
// being emptied in the same cycle, so a stalled output holds exactly one word back.
// Reset (rst, synchronous) clears the suppression and arming state, empties the output
// register and returns the configuration registers to their defaults.
//
module button_chord_detector_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  bcd_pkg::bcd_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output bcd_pkg::bcd_out_t                  out_data,
  input  logic                               cfg_we,
  input  logic [bcd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bcd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers.
  bcd_pkg::bcd_chord_t            home_chord;
  bcd_pkg::bcd_chord_t            quick_chord;
  logic [bcd_pkg::AXIS_W-1:0]     threshold;

  // Suppression and arming state carried between words.
  bcd_pkg::bcd_state_t            state;
  bcd_pkg::bcd_state_t            state_next;
  bcd_pkg::bcd_out_t              result;
  logic                           accept;

  // The output register frees up whenever its word leaves this cycle.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  bcd_step u_step (
    .home_chord  (home_chord),
    .quick_chord (quick_chord),
    .threshold   (threshold),
    .state       (state),
    .item        (in_data),
    .state_next  (state_next),
    .result      (result)
  );

  // Configuration writes are to arrive only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      home_chord  <= '0;
      quick_chord <= '0;
      threshold   <= bcd_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcd_pkg::REG_HOME_BUTTONS: begin
          home_chord.buttons <= cfg_data[bcd_pkg::BUTTON_W-1:0];
        end
        bcd_pkg::REG_HOME_TRIGGERS: begin
          home_chord.lt <= cfg_data[0];
          home_chord.rt <= cfg_data[1];
        end
        bcd_pkg::REG_QUICK_BUTTONS: begin
          quick_chord.buttons <= cfg_data[bcd_pkg::BUTTON_W-1:0];
        end
        bcd_pkg::REG_QUICK_TRIGGERS: begin
          quick_chord.lt <= cfg_data[0];
          quick_chord.rt <= cfg_data[1];
        end
        bcd_pkg::REG_TRIGGER_THRESHOLD: begin
          threshold <= cfg_data[bcd_pkg::AXIS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // State advances only on an accepted word; the result register loads
  // with it and empties when the consumer takes the word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  // A fire command never reports a timer event for either chord.
  a_fire_no_event: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.cmd == bcd_pkg::CMD_FIRE |=>
      out_data.home_event == bcd_pkg::EV_NONE &&
      out_data.quick_event == bcd_pkg::EV_NONE)
    else $error("fire command produced a timer event");

  // The fired chord is disarmed afterwards.
  a_fire_disarms: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.cmd == bcd_pkg::CMD_FIRE |=>
      !state.armed_flags[$past(in_data.fire_action)])
    else $error("fired chord still armed");

  // An arm event leaves the home chord armed, a cancel leaves it disarmed.
  a_home_event_state: assert property (@(posedge clk) disable iff (rst)
    accept |=> (out_data.home_event != bcd_pkg::EV_ARM || state.armed_flags[0]) &&
               (out_data.home_event != bcd_pkg::EV_CANCEL || !state.armed_flags[0]))
    else $error("home event disagrees with armed state");

  // State changes only when a word is accepted.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(state))
    else $error("chord state changed without an accepted word");
`endif

endmodule

FILE: rtl/core/bcd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_step: chord evaluation for one word
// Computes the filtered sample, the timer events and the next suppression
// and arming state from the current state and one input word.
// ----------------------------------------------------------------------------
module bcd_step (
  input  bcd_pkg::bcd_chord_t            home_chord,
  input  bcd_pkg::bcd_chord_t            quick_chord,
  input  logic [bcd_pkg::AXIS_W-1:0]     threshold,
  input  bcd_pkg::bcd_state_t            state,
  input  bcd_pkg::bcd_in_t               item,
  output bcd_pkg::bcd_state_t            state_next,
  output bcd_pkg::bcd_out_t              result
);

  function automatic logic chord_enabled(bcd_pkg::bcd_chord_t c);
    return (c.buttons != '0) || c.lt || c.rt;
  endfunction

  function automatic logic chord_same(bcd_pkg::bcd_chord_t a, bcd_pkg::bcd_chord_t b);
    return (a.buttons == b.buttons) && (a.lt == b.lt) && (a.rt == b.rt);
  endfunction

  function automatic logic chord_supp(bcd_pkg::bcd_chord_t c, bcd_pkg::bcd_state_t s);
    return ((c.buttons & s.suppressed_mask) != '0) ||
           (c.lt && s.suppress_left) || (c.rt && s.suppress_right);
  endfunction

  function automatic logic strictly_contains(bcd_pkg::bcd_chord_t outer,
                                             bcd_pkg::bcd_chord_t inner);
    logic contains;
    contains = ((outer.buttons & inner.buttons) == inner.buttons) &&
               (outer.lt || !inner.lt) && (outer.rt || !inner.rt);
    return chord_enabled(inner) && contains && !chord_same(outer, inner);
  endfunction

  bcd_pkg::bcd_chord_t ch [2];
  bcd_pkg::bcd_chord_t fired;
  bcd_pkg::bcd_state_t s_fire;
  bcd_pkg::bcd_state_t s_samp;
  logic                lp;
  logic                rp;
  logic [1:0]          raw;
  logic [1:0]          arm;
  logic [1:0]          armed_fire;
  logic [1:0]          armed_samp;
  logic [bcd_pkg::EVENT_W-1:0] ev [2];

  // A quick chord identical to an enabled home chord is treated as disabled.
  always_comb begin
    ch[0] = home_chord;
    ch[1] = quick_chord;
    if (chord_enabled(home_chord) && chord_same(home_chord, quick_chord)) begin
      ch[1] = '0;
    end
  end

  assign lp = (item.left_in >= threshold);
  assign rp = (item.right_in >= threshold);
  assign fired = (item.fire_action == bcd_pkg::ACT_QUICK) ? ch[1] : ch[0];

  // Fire: disarm the fired chord, suppress its inputs, then drop any armed chord that
  // now touches a suppressed input.
  always_comb begin
    armed_fire = state.armed_flags;
    armed_fire[item.fire_action] = 1'b0;
    s_fire.suppressed_mask = state.suppressed_mask | fired.buttons;
    s_fire.suppress_left   = state.suppress_left | fired.lt;
    s_fire.suppress_right  = state.suppress_right | fired.rt;
    for (int i = 0; i < 2; i++) begin
      if (armed_fire[i] && chord_supp(ch[i], s_fire)) begin
        armed_fire[i] = 1'b0;
      end
    end
    s_fire.armed_flags = armed_fire;
  end

  // Sample: release suppression of inputs let go, then arm or cancel.
  always_comb begin
    s_samp.suppressed_mask = state.suppressed_mask & item.buttons_in;
    s_samp.suppress_left   = state.suppress_left & lp;
    s_samp.suppress_right  = state.suppress_right & rp;
    s_samp.armed_flags     = 2'b00;
    armed_samp = state.armed_flags;
    for (int i = 0; i < 2; i++) begin
      raw[i] = chord_enabled(ch[i]) &&
               ((item.buttons_in & ch[i].buttons) == ch[i].buttons) &&
               (!ch[i].lt || lp) && (!ch[i].rt || rp);
    end
    for (int i = 0; i < 2; i++) begin
      arm[i] = raw[i] && !chord_supp(ch[i], s_samp) &&
               !(raw[1-i] && strictly_contains(ch[1-i], ch[i]));
      ev[i] = bcd_pkg::EV_NONE;
      if (arm[i] && !state.armed_flags[i]) begin
        armed_samp[i] = 1'b1;
        ev[i] = bcd_pkg::EV_ARM;
      end else if (!arm[i] && state.armed_flags[i]) begin
        armed_samp[i] = 1'b0;
        ev[i] = bcd_pkg::EV_CANCEL;
      end
    end
    s_samp.armed_flags = armed_samp;
  end

  always_comb begin
    if (item.cmd == bcd_pkg::CMD_FIRE) begin
      state_next         = s_fire;
      result.buttons_out = item.buttons_in & ~fired.buttons;
      result.left_out    = fired.lt ? '0 : item.left_in;
      result.right_out   = fired.rt ? '0 : item.right_in;
      result.home_event  = bcd_pkg::EV_NONE;
      result.quick_event = bcd_pkg::EV_NONE;
    end else begin
      state_next         = s_samp;
      result.buttons_out = item.buttons_in & ~s_samp.suppressed_mask;
      result.left_out    = s_samp.suppress_left ? '0 : item.left_in;
      result.right_out   = s_samp.suppress_right ? '0 : item.right_in;
      result.home_event  = ev[0];
      result.quick_event = ev[1];
    end
  end

endmodule

FILE: dv/button_chord_detector_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_chord_detector_unit_tb: self-checking bench of the chord detector
// Drives sample and fire words through the valid/ready input, predicts every
// output word with an in-bench copy of the chord, suppression and arming
// logic, and compares each delivered word field by field under random stalls.
// ----------------------------------------------------------------------------
module button_chord_detector_unit_tb;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 4;

  // Every block input holds a known value from time zero.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  bcd_pkg::bcd_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bcd_pkg::bcd_out_t out_data;
  logic cfg_we = 1'b0;
  logic [bcd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bcd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the configuration registers, updated as they are written.
  logic [bcd_pkg::BUTTON_W-1:0] cfg_home_btn = '0;
  logic [1:0] cfg_home_trg = '0;
  logic [bcd_pkg::BUTTON_W-1:0] cfg_quick_btn = '0;
  logic [1:0] cfg_quick_trg = '0;
  logic [bcd_pkg::AXIS_W-1:0] cfg_thresh = bcd_pkg::THRESHOLD_RESET;

  // Predicted suppression and arming state of the block.
  logic [bcd_pkg::BUTTON_W-1:0] sup_mask = '0;
  logic sup_left = 1'b0;
  logic sup_right = 1'b0;
  logic [1:0] armed = '0;

  bcd_pkg::bcd_out_t expected_words[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // When set, neither the sender nor the receiver inserts any gap.
  logic no_gaps = 1'b0;

  button_chord_detector_unit u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Give up if the run hangs, for example when a result never shows up.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("button_chord_detector_unit test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Chord helpers used by the predictor.
  // ---------------------------------------------------------------------------

  // A chord with no buttons and no triggers is disabled.
  function automatic logic chord_on(bcd_pkg::bcd_chord_t c);
    return (c.buttons != '0) || c.lt || c.rt;
  endfunction

  function automatic logic chord_down(bcd_pkg::bcd_chord_t c,
                                      logic [bcd_pkg::BUTTON_W-1:0] b,
                                      logic [bcd_pkg::AXIS_W-1:0] l,
                                      logic [bcd_pkg::AXIS_W-1:0] r);
    return chord_on(c) && ((b & c.buttons) == c.buttons) &&
           (!c.lt || (l >= cfg_thresh)) && (!c.rt || (r >= cfg_thresh));
  endfunction

  // A chord is blocked while any of its inputs is still suppressed.
  function automatic logic chord_blocked(bcd_pkg::bcd_chord_t c);
    return ((c.buttons & sup_mask) != '0) || (c.lt && sup_left) || (c.rt && sup_right);
  endfunction

  function automatic logic chord_covers(bcd_pkg::bcd_chord_t outer,
                                        bcd_pkg::bcd_chord_t inner);
    return chord_on(inner) && ((outer.buttons & inner.buttons) == inner.buttons) &&
           (outer.lt || !inner.lt) && (outer.rt || !inner.rt) && (outer != inner);
  endfunction

  // Works out the output word for one accepted input word and advances the
  // predicted state, exactly as the block does at the accepting edge.
  function automatic bcd_pkg::bcd_out_t filter_word(bcd_pkg::bcd_in_t w);
    bcd_pkg::bcd_chord_t ch[2];
    bcd_pkg::bcd_chord_t fired;
    bcd_pkg::bcd_out_t res;
    logic [1:0] down;
    logic shadowed;
    logic go;
    logic [bcd_pkg::EVENT_W-1:0] ev;
    int i;
    ch[0].buttons = cfg_home_btn;
    ch[0].lt = cfg_home_trg[0];
    ch[0].rt = cfg_home_trg[1];
    ch[1].buttons = cfg_quick_btn;
    ch[1].lt = cfg_quick_trg[0];
    ch[1].rt = cfg_quick_trg[1];
    // A quick chord identical to an enabled home chord is ignored.
    if (chord_on(ch[0]) && (ch[0] == ch[1])) begin
      ch[1] = '0;
    end
    res.buttons_out = w.buttons_in;
    res.left_out = w.left_in;
    res.right_out = w.right_in;
    res.home_event = bcd_pkg::EV_NONE;
    res.quick_event = bcd_pkg::EV_NONE;
    if (w.cmd == bcd_pkg::CMD_FIRE) begin
      // Only the fired chord's inputs are masked in this word; older
      // suppression is not applied and no events are reported.
      fired = ch[w.fire_action];
      armed[w.fire_action] = 1'b0;
      sup_mask = sup_mask | fired.buttons;
      sup_left = sup_left | fired.lt;
      sup_right = sup_right | fired.rt;
      res.buttons_out = w.buttons_in & ~fired.buttons;
      if (fired.lt) begin
        res.left_out = '0;
      end
      if (fired.rt) begin
        res.right_out = '0;
      end
      for (i = 0; i < 2; i++) begin
        if (armed[i] && chord_blocked(ch[i])) begin
          armed[i] = 1'b0;
        end
      end
    end else begin
      for (i = 0; i < 2; i++) begin
        down[i] = chord_down(ch[i], w.buttons_in, w.left_in, w.right_in);
      end
      // Released inputs leave suppression before the word is masked.
      sup_mask = sup_mask & w.buttons_in;
      sup_left = sup_left && (w.left_in >= cfg_thresh);
      sup_right = sup_right && (w.right_in >= cfg_thresh);
      res.buttons_out = w.buttons_in & ~sup_mask;
      if (sup_left) begin
        res.left_out = '0;
      end
      if (sup_right) begin
        res.right_out = '0;
      end
      for (i = 0; i < 2; i++) begin
        shadowed = down[i ^ 1] && chord_covers(ch[i ^ 1], ch[i]);
        go = down[i] && !chord_blocked(ch[i]) && !shadowed;
        ev = bcd_pkg::EV_NONE;
        if (go && !armed[i]) begin
          armed[i] = 1'b1;
          ev = bcd_pkg::EV_ARM;
        end else if (!go && armed[i]) begin
          armed[i] = 1'b0;
          ev = bcd_pkg::EV_CANCEL;
        end
        if (i == 0) begin
          res.home_event = ev;
        end else begin
          res.quick_event = ev;
        end
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors. Both sample handshakes at the rising edge, where the block's
  // registered outputs still carry their pre-edge values.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      expected_words = {expected_words, filter_word(in_data)};
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    bcd_pkg::bcd_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("output word 0x%0h arrived with nothing expected", out_data);
        mismatch_count++;
      end else begin
        want = expected_words.pop_front();
        check_field("buttons_out", want.buttons_out, out_data.buttons_out);
        check_field("left_out", 32'(want.left_out), 32'(out_data.left_out));
        check_field("right_out", 32'(want.right_out), 32'(out_data.right_out));
        check_field("home_event", 32'(want.home_event), 32'(out_data.home_event));
        check_field("quick_event", 32'(want.quick_event), 32'(out_data.quick_event));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Gap generation and the receiver. Most gaps are zero or short and a few
  // are long; the receiver runs on its own so that its stalls land on every
  // phase of the sender's traffic.
  // ---------------------------------------------------------------------------

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 55) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int unsigned stall;
    @(negedge clk);
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. All tasks are entered and left at a falling edge.
  // ---------------------------------------------------------------------------

  // Presents one word and holds it until accepted. With a zero gap valid is
  // left high so the next word follows back to back; callers that stop
  // sending lower it through drain_block.
  task automatic send_word(bcd_pkg::bcd_in_t w);
    int unsigned gap;
    in_data <= w;
    in_valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (!in_ready);
    @(negedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stops sending and waits until every expected word has been delivered.
  // Every word causes exactly one result, so the block is idle afterwards.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [bcd_pkg::CFG_IDX_W-1:0] idx,
                           logic [bcd_pkg::CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      bcd_pkg::REG_HOME_BUTTONS: cfg_home_btn = value;
      bcd_pkg::REG_HOME_TRIGGERS: cfg_home_trg = value[1:0];
      bcd_pkg::REG_QUICK_BUTTONS: cfg_quick_btn = value;
      bcd_pkg::REG_QUICK_TRIGGERS: cfg_quick_trg = value[1:0];
      bcd_pkg::REG_TRIGGER_THRESHOLD: cfg_thresh = value[bcd_pkg::AXIS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_chords(logic [bcd_pkg::BUTTON_W-1:0] hb, logic [1:0] ht,
                            logic [bcd_pkg::BUTTON_W-1:0] qb, logic [1:0] qt,
                            logic [bcd_pkg::AXIS_W-1:0] th);
    drain_block();
    write_reg(bcd_pkg::REG_HOME_BUTTONS, hb);
    write_reg(bcd_pkg::REG_HOME_TRIGGERS, {30'd0, ht});
    write_reg(bcd_pkg::REG_QUICK_BUTTONS, qb);
    write_reg(bcd_pkg::REG_QUICK_TRIGGERS, {30'd0, qt});
    write_reg(bcd_pkg::REG_TRIGGER_THRESHOLD, {24'd0, th});
  endtask

  function automatic bcd_pkg::bcd_in_t sample_word(logic [bcd_pkg::BUTTON_W-1:0] b,
                                                   logic [bcd_pkg::AXIS_W-1:0] l,
                                                   logic [bcd_pkg::AXIS_W-1:0] r);
    bcd_pkg::bcd_in_t w;
    w.cmd = bcd_pkg::CMD_SAMPLE;
    w.fire_action = bcd_pkg::ACT_HOME;
    w.buttons_in = b;
    w.left_in = l;
    w.right_in = r;
    return w;
  endfunction

  // A fire word carries a full sample; it is filled at random.
  function automatic bcd_pkg::bcd_in_t fire_word(logic act);
    bcd_pkg::bcd_in_t w;
    w.cmd = bcd_pkg::CMD_FIRE;
    w.fire_action = act;
    w.buttons_in = $urandom;
    w.left_in = 8'($urandom_range(0, 255));
    w.right_in = 8'($urandom_range(0, 255));
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed tests.
  // ---------------------------------------------------------------------------

  // Out of reset both chords are disabled: samples pass unchanged, and a
  // fire of a disabled chord only clears its armed bit.
  task automatic test_disabled_passthrough();
    send_word(sample_word('1, 8'd255, 8'd255));
    send_word(sample_word('0, 8'd0, 8'd0));
    send_word(fire_word(bcd_pkg::ACT_HOME));
    send_word(fire_word(bcd_pkg::ACT_QUICK));
  endtask

  // Home is bit 0 plus the left trigger; quick is a strict superset of it.
  // Walks arming at the threshold, cancel, shadowing, both fires and the
  // release of suppressed inputs.
  task automatic test_shadow_and_suppress();
    set_chords(32'h0000_0001, 2'b01, 32'h8000_0001, 2'b11, 8'd128);
    send_word(sample_word(32'h0000_0001, 8'd128, 8'd0));
    send_word(sample_word(32'h0000_0001, 8'd127, 8'd0));
    send_word(sample_word(32'h8000_0001, 8'd255, 8'd128));
    send_word(fire_word(bcd_pkg::ACT_QUICK));
    send_word(sample_word(32'h8000_0001, 8'd255, 8'd255));
    send_word(sample_word('0, 8'd0, 8'd0));
    send_word(sample_word(32'h0000_0001, 8'd200, 8'd0));
    send_word(fire_word(bcd_pkg::ACT_HOME));
    send_word(sample_word(32'h0000_0001, 8'd200, 8'd0));
    send_word(sample_word('1, 8'd0, 8'd0));
    send_word(sample_word('0, 8'd0, 8'd0));
  endtask

  // A quick chord equal to the home chord is treated as disabled.
  task automatic test_identical_chords();
    set_chords(32'h0000_0001, 2'b01, 32'h0000_0001, 2'b01, 8'd128);
    send_word(sample_word(32'h0000_0001, 8'd255, 8'd0));
    send_word(fire_word(bcd_pkg::ACT_QUICK));
    send_word(sample_word('0, 8'd0, 8'd0));
  endtask

  // A trigger-only chord at both threshold extremes.
  task automatic test_threshold_extremes();
    set_chords('0, 2'b10, '0, 2'b00, 8'd0);
    send_word(sample_word('0, 8'd0, 8'd0));
    set_chords('0, 2'b10, '0, 2'b00, 8'd255);
    send_word(sample_word('0, 8'd0, 8'd254));
    send_word(sample_word('0, 8'd255, 8'd255));
    send_word(sample_word('0, 8'd0, 8'd254));
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic.
  // ---------------------------------------------------------------------------

  function automatic logic [bcd_pkg::BUTTON_W-1:0] random_mask();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      return '0;
    end else if (roll == 1) begin
      return '1;
    end
    return $urandom & $urandom & $urandom;
  endfunction

  // Trigger values cluster around the threshold so both sides are hit.
  function automatic logic [bcd_pkg::AXIS_W-1:0] random_axis();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      2: return cfg_thresh;
      3: return cfg_thresh - 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly presses of the configured chords with some noise on top, so the
  // arm, fire, suppress and release paths are all exercised; the rest are
  // random samples and chords with a button dropped.
  function automatic bcd_pkg::bcd_in_t random_word();
    bcd_pkg::bcd_in_t w;
    w.cmd = ($urandom_range(0, 99) < 15) ? bcd_pkg::CMD_FIRE : bcd_pkg::CMD_SAMPLE;
    w.fire_action = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1, 2: w.buttons_in = cfg_home_btn;
      3, 4, 5: w.buttons_in = cfg_quick_btn;
      6: w.buttons_in = cfg_home_btn | cfg_quick_btn;
      default: w.buttons_in = $urandom;
    endcase
    if ($urandom_range(0, 2) == 0) begin
      w.buttons_in = w.buttons_in | ($urandom & $urandom & $urandom);
    end
    if ($urandom_range(0, 5) == 0) begin
      w.buttons_in = w.buttons_in & ~(32'h1 << $urandom_range(0, 31));
    end
    w.left_in = random_axis();
    w.right_in = random_axis();
    return w;
  endfunction

  // Eight phases of about 200 words, each under a fresh chord setting. The
  // quick chord is often built from the home chord so that superset,
  // subset and identical pairs come up.
  task automatic test_random_traffic();
    logic [bcd_pkg::BUTTON_W-1:0] hb;
    logic [bcd_pkg::BUTTON_W-1:0] qb;
    logic [1:0] ht;
    logic [1:0] qt;
    logic [bcd_pkg::AXIS_W-1:0] th;
    int phase;
    int n;
    for (phase = 0; phase < 8; phase++) begin
      hb = random_mask();
      ht = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0, 1: begin
          qb = hb | (32'h1 << $urandom_range(0, 31));
          qt = ht | 2'($urandom_range(0, 3));
        end
        2: begin
          qb = hb & $urandom;
          qt = ht & 2'($urandom_range(0, 3));
        end
        3: begin
          qb = hb;
          qt = ht;
        end
        default: begin
          qb = random_mask();
          qt = 2'($urandom_range(0, 3));
        end
      endcase
      case (phase)
        1: th = 8'd0;
        2: th = 8'd255;
        default: th = 8'($urandom_range(0, 255));
      endcase
      set_chords(hb, ht, qb, qt, th);
      // Some phases run with no gaps on either side at all.
      no_gaps = (phase == 3 || phase == 6);
      for (n = 0; n < 200; n++) begin
        send_word(random_word());
        // Now and then hold off until the block has fully drained.
        if ($urandom_range(0, 99) == 0) begin
          drain_block();
        end
      end
      no_gaps = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_disabled_passthrough();
    test_shadow_and_suppress();
    test_identical_chords();
    test_threshold_extremes();
    test_random_traffic();
    drain_block();
    if (mismatch_count == 0) begin
      $display("button_chord_detector_unit test passed");
    end else begin
      $display("button_chord_detector_unit test failed");
    end
    $finish;
  end

endmodule
